@@ rtl/tks_pkg.sv @@
`timescale 1ns / 1ps
// Package for the touch key scanner: field widths, register indexes and
// the per-key note table. No dependencies.
package tks_pkg;

  localparam int COUNT_W     = 16;  // sensor_count field width
  localparam int CHAN_W      = 3;   // channel / key field width
  localparam int PERIOD_W    = 8;
  localparam int DUTY_W      = 10;
  localparam int THRESH_W    = 16;
  localparam int LIMIT_W     = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int TABLE_KEYS  = 7;
  localparam int MAX_CHANS   = 8;   // channel field wraps after eight

  localparam int DEF_NUM_KEYS   = 7;
  localparam int DEF_COUNT_BITS = 16;

  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 8'd13;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd0;

  typedef logic [CHAN_W-1:0]    chan_t;
  typedef logic [PERIOD_W-1:0]  period_t;
  typedef logic [DUTY_W-1:0]    duty_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_TOUCH_THRESHOLD = 1'b0;
  localparam cfg_idx_t CFG_RELEASE_LIMIT   = 1'b1;

  // One result item.
  typedef struct packed {
    chan_t   scanned_channel;
    logic    touched;
    logic    note_load;
    logic    note_playing;
    chan_t   note_key;
    period_t tone_period;
    duty_t   tone_duty;
    chan_t   next_channel;
  } result_t;

  function automatic period_t period_of(chan_t key);
    period_t p;
    case (key)
      3'd0:    p = 8'd126;
      3'd1:    p = 8'd141;
      3'd2:    p = 8'd158;
      3'd3:    p = 8'd178;
      3'd4:    p = 8'd188;
      3'd5:    p = 8'd212;
      3'd6:    p = 8'd238;
      default: p = '0;
    endcase
    return p;
  endfunction

  function automatic duty_t duty_of(chan_t key);
    duty_t d;
    case (key)
      3'd0:    d = 10'd253;
      3'd1:    d = 10'd283;
      3'd2:    d = 10'd317;
      3'd3:    d = 10'd357;
      3'd4:    d = 10'd377;
      3'd5:    d = 10'd425;
      3'd6:    d = 10'd477;
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

@@ rtl/tks_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the count input and the scan result.
// Depends on tks_pkg for field widths.
interface tks_in_if;
  logic                         valid;
  logic                         ready;
  logic [tks_pkg::COUNT_W-1:0]  sensor_count;

  modport source (output valid, output sensor_count, input ready);
  modport sink   (input valid, input sensor_count, output ready);
endinterface

interface tks_out_if;
  logic            valid;
  logic            ready;
  tks_pkg::chan_t   scanned_channel;
  logic            touched;
  logic            note_load;
  logic            note_playing;
  tks_pkg::chan_t   note_key;
  tks_pkg::period_t tone_period;
  tks_pkg::duty_t   tone_duty;
  tks_pkg::chan_t   next_channel;

  modport source (output valid, output scanned_channel, output touched,
                  output note_load, output note_playing, output note_key,
                  output tone_period, output tone_duty, output next_channel,
                  input ready);
  modport sink   (input valid, input scanned_channel, input touched,
                  input note_load, input note_playing, input note_key,
                  input tone_period, input tone_duty, input next_channel,
                  output ready);
endinterface

@@ rtl/touch_key_scan_note_select.sv @@
`timescale 1ns / 1ps
// Touch key scanner with note selection: top level.
// Depends on tks_pkg and the channel interfaces in tks_if.sv.
//
// A result passes through the input register, then the result register; one
//   count per cycle sustained while the result side holds ready high.
// The input register and the result register decouple the two sides, so a
//   count is still taken while one finished result waits downstream.
// Reset (rst_n low, synchronous): no note sounding, scan at channel 0,
//   threshold 0, release limit 13, both pipeline stages empty.
module touch_key_scan_note_select #(
  parameter int NUM_KEYS   = tks_pkg::DEF_NUM_KEYS,
  parameter int COUNT_BITS = tks_pkg::DEF_COUNT_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  tks_in_if.sink                       in_ch,
  tks_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  tks_pkg::cfg_idx_t            cfg_index,
  input  logic [tks_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // Channels scanned; the channel field only holds eight.
  localparam int SCAN_LEN = (NUM_KEYS > tks_pkg::MAX_CHANS) ? tks_pkg::MAX_CHANS
                                                             : NUM_KEYS;
  localparam tks_pkg::chan_t LAST_CHAN = tks_pkg::CHAN_W'(SCAN_LEN - 1);
  localparam tks_pkg::chan_t NO_TABLE  = tks_pkg::CHAN_W'(tks_pkg::TABLE_KEYS);
  // Only the low COUNT_BITS of a count are compared.
  localparam logic [tks_pkg::COUNT_W-1:0] COUNT_MASK =
      (COUNT_BITS >= tks_pkg::COUNT_W) ? {tks_pkg::COUNT_W{1'b1}}
                                       : tks_pkg::COUNT_W'((64'd1 << COUNT_BITS) - 64'd1);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [tks_pkg::THRESH_W-1:0] threshold_r;
  logic [tks_pkg::LIMIT_W-1:0]  limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= tks_pkg::THRESH_RESET;
      limit_r     <= tks_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tks_pkg::CFG_TOUCH_THRESHOLD: threshold_r <= cfg_wdata[tks_pkg::THRESH_W-1:0];
        tks_pkg::CFG_RELEASE_LIMIT:   limit_r     <= cfg_wdata[tks_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stage handshake: input register feeds the result register.
  // ---------------------------------------------------------------------
  logic                         in_valid_r;
  logic [tks_pkg::COUNT_W-1:0]  count_r;
  logic                         out_valid_r;
  tks_pkg::result_t             res_r;
  tks_pkg::result_t             res_nxt;

  logic step;      // input register hands its count to the result register
  logic in_xfer;   // a count transfer on the input channel

  assign step      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || step;
  assign in_xfer   = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  // Payload: hold while the stage stalls.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      count_r <= in_ch.sensor_count & COUNT_MASK;
    end
  end

  // ---------------------------------------------------------------------
  // Scanner state
  // ---------------------------------------------------------------------
  tks_pkg::chan_t               scan_chan_r,   scan_chan_nxt;
  tks_pkg::chan_t               active_key_r,  active_key_nxt;
  logic                         key_valid_r,   key_valid_nxt;
  logic [tks_pkg::LIMIT_W-1:0]  rel_cnt_r,     rel_cnt_nxt;
  tks_pkg::period_t             period_r,      period_nxt;
  tks_pkg::duty_t               duty_r,        duty_nxt;

  logic                         touch;
  logic                         load;
  logic [tks_pkg::LIMIT_W-1:0]  rel_inc;

  always_comb begin
    touch   = count_r < threshold_r;
    // Start a note only on a key with a table entry that is not sounding.
    load    = touch && (scan_chan_r < NO_TABLE)
              && !(key_valid_r && (active_key_r == scan_chan_r));
    rel_inc = rel_cnt_r + 1'b1;

    active_key_nxt = active_key_r;
    key_valid_nxt  = key_valid_r;
    period_nxt     = period_r;
    duty_nxt       = duty_r;
    rel_cnt_nxt    = rel_cnt_r;

    if (load) begin
      active_key_nxt = scan_chan_r;
      key_valid_nxt  = 1'b1;
      period_nxt     = tks_pkg::period_of(scan_chan_r);
      duty_nxt       = tks_pkg::duty_of(scan_chan_r);
    end

    if (touch) begin
      rel_cnt_nxt = '0;
    end else if (rel_inc == limit_r) begin
      // Release: silence the note and forget the key.
      key_valid_nxt = 1'b0;
      rel_cnt_nxt   = '0;
    end else begin
      rel_cnt_nxt = rel_inc;
    end

    // Advance the scan, wrapping after the last channel.
    scan_chan_nxt = (scan_chan_r == LAST_CHAN) ? '0 : scan_chan_r + 1'b1;

    res_nxt.scanned_channel = scan_chan_r;
    res_nxt.touched         = touch;
    res_nxt.note_load       = load;
    res_nxt.note_playing    = key_valid_nxt;
    res_nxt.note_key        = key_valid_nxt ? active_key_nxt : '0;
    res_nxt.tone_period     = period_nxt;
    res_nxt.tone_duty       = duty_nxt;
    res_nxt.next_channel    = scan_chan_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_chan_r  <= '0;
      active_key_r <= '0;
      key_valid_r  <= 1'b0;
      rel_cnt_r    <= '0;
      period_r     <= '0;
      duty_r       <= '0;
    end else if (step) begin
      scan_chan_r  <= scan_chan_nxt;
      active_key_r <= active_key_nxt;
      key_valid_r  <= key_valid_nxt;
      rel_cnt_r    <= rel_cnt_nxt;
      period_r     <= period_nxt;
      duty_r       <= duty_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.scanned_channel = res_r.scanned_channel;
  assign out_ch.touched         = res_r.touched;
  assign out_ch.note_load       = res_r.note_load;
  assign out_ch.note_playing    = res_r.note_playing;
  assign out_ch.note_key        = res_r.note_key;
  assign out_ch.tone_period     = res_r.tone_period;
  assign out_ch.tone_duty       = res_r.tone_duty;
  assign out_ch.next_channel    = res_r.next_channel;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // A started note is always a touched, sounding note.
  a_load_implies_play: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r |-> (!res_r.note_load || (res_r.touched && res_r.note_playing)))
    else $error("note_load without touch or playing");

  // Silent results report key zero.
  a_silent_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && !res_r.note_playing) |-> (res_r.note_key == '0))
    else $error("note_key nonzero while silent");

  // The scan pointer stays inside the scanned range.
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
      scan_chan_r <= LAST_CHAN)
    else $error("scan channel out of range");

  // Scanner state moves only when a count leaves the input register.
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
      !step |=> $stable(scan_chan_r) && $stable(key_valid_r) && $stable(rel_cnt_r))
    else $error("scanner state changed without a count");

endmodule

@@ dv/touch_key_scan_note_select_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the touch key scanner with note selection.
// Uses tks_pkg and the channel interfaces of tks_if.sv; holds its own
// scan predictor and checks every result transfer against it.
module touch_key_scan_note_select_test;
  import tks_pkg::*;

  // The scan wraps after NUM_KEYS channels, capped by the channel field.
  localparam int SCAN_LEN    = (DEF_NUM_KEYS > MAX_CHANS) ? MAX_CHANS : DEF_NUM_KEYS;
  localparam int MAX_GAP     = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Note table packed key 6 down to key 0: tone period and 10-bit duty.
  localparam logic [TABLE_KEYS*PERIOD_W-1:0] NOTE_PERIODS = {
    8'd238, 8'd212, 8'd188, 8'd178, 8'd158, 8'd141, 8'd126
  };
  localparam logic [TABLE_KEYS*DUTY_W-1:0] NOTE_DUTIES = {
    10'd477, 10'd425, 10'd377, 10'd357, 10'd317, 10'd283, 10'd253
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tks_in_if  in_if ();
  tks_out_if out_if ();

  touch_key_scan_note_select uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor copy of the configuration and the scan state.
  logic [THRESH_W-1:0] pred_threshold;
  logic [LIMIT_W-1:0]  pred_limit;
  chan_t               scan_ch;
  chan_t               sound_key;
  logic                sounding;
  logic [LIMIT_W-1:0]  quiet_scans;
  period_t             held_period;
  duty_t               held_duty;

  // Expected scan results, oldest first.
  result_t scan_results_q[$];
  result_t want_res;

  int errors;
  int counts_sent;
  int results_seen;
  int touches_seen;
  int notes_started;
  int notes_stopped;
  int cycle_count;
  bit no_idle;  // set for stretches where neither side idles

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold the predictor at its reset state.
  task automatic reset_scan_model();
    pred_threshold = THRESH_RESET;
    pred_limit     = LIMIT_RESET;
    scan_ch        = '0;
    sound_key      = '0;
    sounding       = 1'b0;
    quiet_scans    = '0;
    held_period    = '0;
    held_duty      = '0;
  endtask

  // Advance the predictor by one count and return the scan result it causes.
  function automatic result_t predict_scan(input logic [COUNT_W-1:0] count);
    result_t r;
    chan_t   ch;
    logic    hit;
    logic    load;
    int      nxt;
    ch = scan_ch;
    if (ch >= SCAN_LEN) ch = '0;
    hit  = count < pred_threshold;
    load = 1'b0;
    if (hit) begin
      // A touch on the key already sounding does not restart its note.
      if (ch < TABLE_KEYS && !(sounding && sound_key == ch)) begin
        sound_key   = ch;
        sounding    = 1'b1;
        held_period = NOTE_PERIODS[ch*PERIOD_W +: PERIOD_W];
        held_duty   = NOTE_DUTIES[ch*DUTY_W +: DUTY_W];
        load        = 1'b1;
      end
      quiet_scans = '0;
    end else begin
      // The counter runs even when silent and wraps past 255.
      quiet_scans = quiet_scans + 1'b1;
      if (quiet_scans == pred_limit) begin
        if (sounding) notes_stopped++;
        sounding    = 1'b0;
        quiet_scans = '0;
      end
    end
    nxt = ch + 1;
    if (nxt >= SCAN_LEN) nxt = 0;
    scan_ch = chan_t'(nxt);

    r.scanned_channel = ch;
    r.touched         = hit;
    r.note_load       = load;
    r.note_playing    = sounding;
    r.note_key        = sounding ? sound_key : chan_t'(0);
    r.tone_period     = held_period;
    r.tone_duty       = held_duty;
    r.next_channel    = scan_ch;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    errors++;
    $display("mismatch on result %0d, %s: got %0d, expected %0d",
             results_seen, what, got, want);
  endtask

  // Draw a count that is (or is not) below the current threshold.
  function automatic logic [COUNT_W-1:0] pick_count(input bit want_touch);
    if (want_touch && pred_threshold != 0)
      return COUNT_W'($urandom_range(pred_threshold - 1, 0));
    return COUNT_W'($urandom_range(COUNT_MAX, pred_threshold));
  endfunction

  // Send one count: idle a random number of cycles, then hold valid until
  // the transfer and record what it must produce.
  task automatic send_count(input logic [COUNT_W-1:0] count);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.sensor_count = count;
    in_if.valid        = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    scan_results_q.push_back(predict_scan(count));
    counts_sent++;
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic wait_idle();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (scan_results_q.size() != 0) @(negedge clk);
  endtask

  // Write one register while the block is idle; mirror it in the predictor.
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_index = idx;
    cfg_wdata = data;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_TOUCH_THRESHOLD) pred_threshold = data[THRESH_W-1:0];
    else pred_limit = data[LIMIT_W-1:0];
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] thr,
                            input logic [CFG_DATA_W-1:0] lim);
    write_reg(CFG_TOUCH_THRESHOLD, thr);
    write_reg(CFG_RELEASE_LIMIT, lim);
  endtask

  // Reset values: threshold zero, so no count is a touch, not even zero;
  // the counter still restarts at the default limit while silent.
  task automatic test_reset_state();
    send_count('0);
    send_count(COUNT_MAX);
    send_count(16'h5555);
    send_count(16'hAAAA);
    repeat (12) send_count(COUNT_W'($urandom));
  endtask

  // Touch every key in turn, then retouch the sounding key: no reload.
  task automatic test_each_key();
    set_config(16'd1000, 16'd200);
    repeat (SCAN_LEN) send_count('0);
    send_count(16'd999);                 // first key again, another one sounding
    send_count(16'd1000);                // exactly at threshold: untouched
    repeat (SCAN_LEN - 2) send_count(pick_count(1'b0));
    send_count(16'd500);                 // that key still sounding: no new note
  endtask

  // Threshold at its top, limit at both ends; upper data bits must be dropped.
  task automatic test_extremes();
    set_config(COUNT_MAX, 16'hFF01);
    send_count(COUNT_MAX - 1'b1);        // touch
    send_count(COUNT_MAX);               // untouched: limit one stops the note
    send_count('0);
    send_count(COUNT_MAX);
    write_reg(CFG_RELEASE_LIMIT, 16'h00FF);
    send_count('0);
    repeat (4) send_count(COUNT_MAX);
  endtask

  // Limit zero, written below the running count: the counter has to wrap
  // past 255 before the note stops.
  task automatic test_limit_wrap();
    set_config(16'd40000, 16'd200);
    send_count('0);
    repeat (10) send_count(pick_count(1'b0));
    write_reg(CFG_RELEASE_LIMIT, 16'd0);
    repeat (247) send_count(pick_count(1'b0));
  endtask

  // Random phases: new settings per phase, touch rate varied, a share of
  // raw noise counts, and one stretch without idling every fourth phase.
  task automatic test_random();
    int pct;
    int sel;
    logic [CFG_DATA_W-1:0] thr;
    logic [CFG_DATA_W-1:0] lim;
    for (int phase = 0; phase < 8; phase++) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) thr = '0;
      else if (sel == 1) thr = '1;
      else thr = CFG_DATA_W'($urandom);
      sel = $urandom_range(0, 9);
      if (sel == 0) lim = 16'd255;
      else if (sel == 1) lim = CFG_DATA_W'($urandom);
      else lim = CFG_DATA_W'($urandom_range(24, 1));
      set_config(thr, lim);
      no_idle = (phase % 4 == 3);
      pct = $urandom_range(60, 5);
      for (int i = 0; i < 16; i++) begin
        // Pause once mid-phase until every result is back.
        if (phase == 2 && i == 8) wait_idle();
        if ($urandom_range(0, 9) == 0) send_count(COUNT_W'($urandom));
        else send_count(pick_count($urandom_range(99, 0) < pct));
      end
    end
    no_idle = 1'b0;
  endtask

  // Result side: stall a random number of cycles per result, then accept.
  initial begin : result_sink
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready = 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  // Check each result transfer against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (scan_results_q.size() == 0) begin
        errors++;
        $display("result %0d arrived with nothing expected", results_seen);
      end else begin
        want_res = scan_results_q.pop_front();
        if (out_if.scanned_channel !== want_res.scanned_channel)
          report_mismatch("scanned_channel", 16'(out_if.scanned_channel),
                          16'(want_res.scanned_channel));
        if (out_if.touched !== want_res.touched)
          report_mismatch("touched", 16'(out_if.touched), 16'(want_res.touched));
        if (out_if.note_load !== want_res.note_load)
          report_mismatch("note_load", 16'(out_if.note_load), 16'(want_res.note_load));
        if (out_if.note_playing !== want_res.note_playing)
          report_mismatch("note_playing", 16'(out_if.note_playing),
                          16'(want_res.note_playing));
        if (out_if.note_key !== want_res.note_key)
          report_mismatch("note_key", 16'(out_if.note_key), 16'(want_res.note_key));
        if (out_if.tone_period !== want_res.tone_period)
          report_mismatch("tone_period", 16'(out_if.tone_period),
                          16'(want_res.tone_period));
        if (out_if.tone_duty !== want_res.tone_duty)
          report_mismatch("tone_duty", 16'(out_if.tone_duty), 16'(want_res.tone_duty));
        if (out_if.next_channel !== want_res.next_channel)
          report_mismatch("next_channel", 16'(out_if.next_channel),
                          16'(want_res.next_channel));
        if (want_res.touched) touches_seen++;
        if (want_res.note_load) notes_started++;
      end
      results_seen++;
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, scan_results_q.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    errors        = 0;
    counts_sent   = 0;
    results_seen  = 0;
    touches_seen  = 0;
    notes_started = 0;
    notes_stopped = 0;
    cycle_count   = 0;
    no_idle       = 1'b0;
    in_if.valid        = 1'b0;
    in_if.sensor_count = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_TOUCH_THRESHOLD;
    cfg_wdata = '0;
    reset_scan_model();

    // Hold reset low, then release it on a falling edge.
    rst_n = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_each_key();
    test_extremes();
    test_limit_wrap();
    test_random();

    // Drain, then let the pipeline settle before the verdict.
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("sent %0d counts, checked %0d results: %0d touches, %0d notes started,",
             counts_sent, results_seen, touches_seen, notes_started);
    $display("%0d notes released by the counter, %0d mismatches",
             notes_stopped, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ touch_key_scan_note_select.f @@
rtl/tks_pkg.sv
rtl/tks_if.sv
rtl/touch_key_scan_note_select.sv
dv/touch_key_scan_note_select_test.sv
